@@ hdl/least_loaded_qualified_assigner_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the assigner modules
// Both macros sample on i_clk and are quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_QUALIFIED_ASSIGNER_DEFINES_SVH
`define LEAST_LOADED_QUALIFIED_ASSIGNER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LLQA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LLQA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/llqa_pkg.sv @@
// ----------------------------------------------------------------------------
// llqa_pkg
// Types and constants shared by the least-loaded qualified assigner.
// ----------------------------------------------------------------------------
package llqa_pkg;

    // default table depth
    localparam int WORKER_SLOTS_DEF = 16;

    // field widths
    localparam int ACT_W   = 5;
    localparam int SLOT_FW = 4;
    localparam int ID_W    = 16;
    localparam int SKILL_W = 8;
    localparam int COST_W  = 16;
    localparam int HOURS_W = 16;
    localparam int BUSY_W  = 32;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TASK = 1'b1;

    // input beat
    typedef struct packed {
        logic               op;
        logic [SLOT_FW-1:0] slot;
        logic [ID_W-1:0]    worker_id;
        logic [SKILL_W-1:0] worker_skill;
        logic [COST_W-1:0]  worker_cost;
        logic [SKILL_W-1:0] required_skill;
        logic [HOURS_W-1:0] task_hours;
    } t_in;

    // result beat
    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] chosen_id;
    } t_out;

    // one worker table entry
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SKILL_W-1:0] skill;
        logic [COST_W-1:0]  cost;
        logic [BUSY_W-1:0]  busy;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the input beat
        logic cfg_wr;      // write active worker count
        logic clr_idx;     // restart the table scan
        logic clr_flags;   // forget best and match
        logic issue;       // read next table entry
        logic match_phase; // 0: find best, 1: find first id match
        logic load_wr;     // write loaded entry
        logic busy_wr;     // write updated busy time
        logic emit;        // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_task;
        logic n_zero;
        logic last;
        logic have;
    } t_sts;

endpackage

@@ hdl/llqa_dp.sv @@
// ----------------------------------------------------------------------------
// llqa_dp
// Worker table, scan compare, id match, saturating busy update, result reg.
// ----------------------------------------------------------------------------
`include "least_loaded_qualified_assigner_defines.svh"

module llqa_dp #(
    parameter int WORKER_SLOTS = llqa_pkg::WORKER_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  llqa_pkg::t_in              i_in_data,
    input  logic [llqa_pkg::ACT_W-1:0] i_cfg_data,
    input  llqa_pkg::t_cmd             i_cmd,
    output llqa_pkg::t_sts             o_sts,
    output llqa_pkg::t_out             o_out_data
);

    localparam int SLOT_W = (WORKER_SLOTS > 1) ? $clog2(WORKER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(WORKER_SLOTS + 1);
    localparam int BUSY_W = llqa_pkg::BUSY_W;

    logic [llqa_pkg::ACT_W-1:0]   r_act;
    llqa_pkg::t_in                r_item;
    llqa_pkg::t_entry             r_mem [WORKER_SLOTS];
    llqa_pkg::t_entry             r_rd;
    logic [SLOT_W-1:0]            r_idx;
    logic                         r_pend;
    logic [SLOT_W-1:0]            r_pend_idx;
    logic                         r_have;
    logic [BUSY_W-1:0]            r_best_busy;
    logic [llqa_pkg::COST_W-1:0]  r_best_cost;
    logic [llqa_pkg::ID_W-1:0]    r_best_id;
    logic                         r_matched;
    logic [SLOT_W-1:0]            r_match_idx;
    llqa_pkg::t_entry             r_match_ent;
    llqa_pkg::t_out               r_out;

    logic [CNT_W-1:0]   w_n;
    logic               w_better;
    logic               w_upd;
    logic               w_hit;
    logic               w_slot_ok;
    logic [BUSY_W:0]    w_sum;
    logic [BUSY_W-1:0]  w_sat;
    logic               w_wr_en;
    logic [SLOT_W-1:0]  w_wr_addr;
    llqa_pkg::t_entry   w_wr_data;

    // active slot count, clamped to the table depth
    always_comb begin
        if (32'(r_act) >= WORKER_SLOTS) begin
            w_n = CNT_W'(WORKER_SLOTS);
        end else begin
            w_n = CNT_W'(r_act);
        end
    end

    assign o_sts.is_task = (i_in_data.op == llqa_pkg::OP_TASK);
    assign o_sts.n_zero  = (w_n == '0);
    assign o_sts.last    = (r_idx == SLOT_W'(w_n - CNT_W'(1)));
    assign o_sts.have    = r_have;

    // qualified and better than the best so far
    assign w_better = (r_rd.skill >= r_item.required_skill) &&
                      (!r_have || (r_rd.busy < r_best_busy) ||
                       ((r_rd.busy == r_best_busy) && (r_rd.cost < r_best_cost)));
    assign w_upd = r_pend && !i_cmd.match_phase && w_better;
    assign w_hit = r_pend && i_cmd.match_phase && !r_matched && (r_rd.id == r_best_id);

    // saturating busy update
    assign w_sum = {1'b0, r_match_ent.busy} + (BUSY_W + 1)'(r_item.task_hours);
    assign w_sat = w_sum[BUSY_W] ? {BUSY_W{1'b1}} : w_sum[BUSY_W-1:0];

    // table write port: load beat or busy update
    assign w_slot_ok = (32'(r_item.slot) < WORKER_SLOTS);
    assign w_wr_en   = (i_cmd.load_wr && w_slot_ok) || i_cmd.busy_wr;
    always_comb begin
        if (i_cmd.busy_wr) begin
            w_wr_addr      = r_match_idx;
            w_wr_data      = r_match_ent;
            w_wr_data.busy = w_sat;
        end else begin
            w_wr_addr       = SLOT_W'(r_item.slot);
            w_wr_data.id    = r_item.worker_id;
            w_wr_data.skill = r_item.worker_skill;
            w_wr_data.cost  = r_item.worker_cost;
            w_wr_data.busy  = '0;
        end
    end

    // worker table, registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd <= r_mem[r_idx];
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_have    <= 1'b0;
            r_matched <= 1'b0;
        end else begin
            if (i_cmd.cfg_wr) begin
                r_act <= i_cfg_data;
            end
            r_pend <= i_cmd.issue;
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end else if (i_cmd.issue) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
            if (i_cmd.clr_flags) begin
                r_have    <= 1'b0;
                r_matched <= 1'b0;
            end else begin
                if (w_upd) begin
                    r_have <= 1'b1;
                end
                if (w_hit) begin
                    r_matched <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.issue) begin
            r_pend_idx <= r_idx;
        end
        if (w_upd) begin
            r_best_busy <= r_rd.busy;
            r_best_cost <= r_rd.cost;
            r_best_id   <= r_rd.id;
        end
        if (w_hit) begin
            r_match_idx <= r_pend_idx;
            r_match_ent <= r_rd;
        end
        if (i_cmd.emit) begin
            r_out.found     <= r_have;
            r_out.chosen_id <= r_have ? r_best_id : '0;
        end
    end

    assign o_out_data = r_out;

    // checks
    `LLQA_ASSERT_SAME(a_update_has_match, i_cmd.busy_wr, r_matched, "busy update without id match")
    `LLQA_ASSERT_SAME(a_match_needs_best, r_matched, r_have, "id match without a chosen worker")
    `LLQA_ASSERT_SAME(a_busy_no_wrap, i_cmd.busy_wr, w_sat >= r_match_ent.busy, "busy time wrapped")

endmodule

@@ hdl/llqa_ctrl.sv @@
// ----------------------------------------------------------------------------
// llqa_ctrl
// Sequencer for load and task beats, result and config handshakes.
// ----------------------------------------------------------------------------
`include "least_loaded_qualified_assigner_defines.svh"

module llqa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  llqa_pkg::t_sts  i_sts,
    output llqa_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_SCAN_END,
        S_CHECK,
        S_MATCH,
        S_MATCH_END,
        S_UPDATE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_in_acc;
    logic   w_out_free;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // commands and next state
    always_comb begin
        o_cmd             = '0;
        o_cmd.capture     = w_in_acc;
        o_cmd.cfg_wr      = i_cfg_valid && (r_state == S_IDLE);
        o_cmd.match_phase = (r_state == S_MATCH) || (r_state == S_MATCH_END);
        n_state           = r_state;
        n_out_valid       = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    o_cmd.clr_idx   = 1'b1;
                    o_cmd.clr_flags = 1'b1;
                    if (!i_sts.is_task) begin
                        n_state = S_LOAD;
                    end else if (i_sts.n_zero) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.clr_idx = 1'b1;
                n_state       = i_sts.have ? S_MATCH : S_EMIT;
            end
            S_MATCH: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last) begin
                    n_state = S_MATCH_END;
                end
            end
            S_MATCH_END: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.busy_wr = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // checks
    `LLQA_ASSERT_NEXT(a_busy_after_accept, w_in_acc, o_in_stall, "no stall after accepted beat")
    `LLQA_ASSERT_NEXT(a_emit_sets_valid, o_cmd.emit, r_out_valid, "emitted result not presented")

endmodule

@@ hdl/least_loaded_qualified_assigner.sv @@
// ----------------------------------------------------------------------------
// least_loaded_qualified_assigner
// Picks the least-busy qualified worker for each task beat and books its time.
// ----------------------------------------------------------------------------
// One beat is handled at a time. The worker table has a single read port:
// for a task beat one pass reads each of the n active slots (n =
// min(active_workers, WORKER_SLOTS)) to find the best worker, a second pass
// finds the first slot holding its id, whose busy time is then rewritten.
// With n zero the beat goes straight to the result, and with no qualified
// worker the second pass is skipped. A new result waits while i_out_stall
// holds the previous one. A finished result sits in the output register
// while the next beat is accepted.
// ----------------------------------------------------------------------------
module least_loaded_qualified_assigner #(
    parameter int WORKER_SLOTS = llqa_pkg::WORKER_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  llqa_pkg::t_in              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output llqa_pkg::t_out             o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [llqa_pkg::ACT_W-1:0] i_cfg_data
);

    llqa_pkg::t_cmd w_cmd;
    llqa_pkg::t_sts w_sts;

    // sequencer
    llqa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // worker table and compare
    llqa_dp #(
        .WORKER_SLOTS (WORKER_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule
